>>> src/pfrc_pkg.sv
// Shared constants, types and conversion functions for the PCM format and rate converter.
package pfrc_pkg;

   localparam int COUNT_BITS    = 24;
   localparam int MAX_RATIO     = 12;
   localparam int N_BITS        = $clog2(MAX_RATIO + 1);
   localparam int CAP_BITS      = 24;
   localparam int FW_BITS       = 24;
   localparam int CMP_BITS      = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;
   localparam int RATE_BITS     = 16;
   localparam int SAMPLE_BITS   = 16;
   localparam int PHASE_BITS    = 18;
   localparam int Q_BITS        = 20;
   localparam int RATE_MIN      = 4000;
   localparam int RATE_MAX      = 48000;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

   localparam logic signed [Q_BITS-1:0] Q_PHASE_MAX = Q_BITS'(2 ** (PHASE_BITS - 1) - 1);
   localparam logic signed [Q_BITS-1:0] Q_PHASE_MIN = ~Q_PHASE_MAX;
   localparam logic signed [16:0] WIDE_MAX = 17'sd32767;
   localparam logic signed [16:0] WIDE_MIN = -17'sd32768;
   localparam logic [7:0] OFFSET_ZERO = 8'd128;

   typedef enum logic [2:0] {
      REG_SRC_WIDE    = 3'd0,
      REG_SRC_STEREO  = 3'd1,
      REG_DST_WIDE    = 3'd2,
      REG_DST_STEREO  = 3'd3,
      REG_SRC_RATE    = 3'd4,
      REG_DST_RATE    = 3'd5,
      REG_FRAME_LIMIT = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic                 src_wide;
      logic                 src_stereo;
      logic                 dst_wide;
      logic                 dst_stereo;
      logic [RATE_BITS-1:0] src_rate;
      logic [RATE_BITS-1:0] dst_rate;
      logic [CAP_BITS-1:0]  frame_limit;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] first;
      logic [SAMPLE_BITS-1:0] second;
      logic                   final_frame;
   } entry_type;

   // 8-bit offset samples: (b - 128) * 256 is the byte with its top bit flipped, shifted up.
   function automatic logic signed [SAMPLE_BITS-1:0] widen(input logic [SAMPLE_BITS-1:0] raw,
                                                           input logic wide);
      logic [7:0] off;
      off = raw[7:0] ^ OFFSET_ZERO;
      return wide ? raw : {off, 8'h00};
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] narrow(input logic signed [16:0] v,
                                                     input logic wide);
      logic [SAMPLE_BITS-1:0] t;
      logic [7:0]             b;
      if (v > WIDE_MAX) begin
         t = WIDE_MAX[15:0];
      end else if (v < WIDE_MIN) begin
         t = WIDE_MIN[15:0];
      end else begin
         t = v[15:0];
      end
      b = t[15:8] ^ OFFSET_ZERO;
      return wide ? t : {8'h00, b};
   endfunction

   function automatic logic [RATE_BITS-1:0] clamp_rate(input logic [RATE_BITS-1:0] r);
      if (r < RATE_BITS'(RATE_MIN)) begin
         return RATE_BITS'(RATE_MIN);
      end else if (r > RATE_BITS'(RATE_MAX)) begin
         return RATE_BITS'(RATE_MAX);
      end
      return r;
   endfunction

   function automatic logic [FW_BITS-1:0] frames_of(input logic [COUNT_BITS-1:0] c);
      logic [CMP_BITS-1:0] t;
      t = CMP_BITS'(c);
      return t[FW_BITS-1:0];
   endfunction

endpackage

>>> src/pfrc_csr.sv
// Configuration registers behind the APB-style port.
module pfrc_csr import pfrc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_SRC_WIDE:    cfg_in.src_wide    = pwdata[0];
            REG_SRC_STEREO:  cfg_in.src_stereo  = pwdata[0];
            REG_DST_WIDE:    cfg_in.dst_wide    = pwdata[0];
            REG_DST_STEREO:  cfg_in.dst_stereo  = pwdata[0];
            REG_SRC_RATE:    cfg_in.src_rate    = pwdata[RATE_BITS-1:0];
            REG_DST_RATE:    cfg_in.dst_rate    = pwdata[RATE_BITS-1:0];
            REG_FRAME_LIMIT: cfg_in.frame_limit = pwdata[CAP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SRC_WIDE:    prdata = CSR_DATA_BITS'(cfg_ff.src_wide);
         REG_SRC_STEREO:  prdata = CSR_DATA_BITS'(cfg_ff.src_stereo);
         REG_DST_WIDE:    prdata = CSR_DATA_BITS'(cfg_ff.dst_wide);
         REG_DST_STEREO:  prdata = CSR_DATA_BITS'(cfg_ff.dst_stereo);
         REG_SRC_RATE:    prdata = CSR_DATA_BITS'(cfg_ff.src_rate);
         REG_DST_RATE:    prdata = CSR_DATA_BITS'(cfg_ff.dst_rate);
         REG_FRAME_LIMIT: prdata = CSR_DATA_BITS'(cfg_ff.frame_limit);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_wide    <= 1'b1;
         cfg_ff.src_stereo  <= 1'b0;
         cfg_ff.dst_wide    <= 1'b1;
         cfg_ff.dst_stereo  <= 1'b0;
         cfg_ff.src_rate    <= RATE_BITS'(8000);
         cfg_ff.dst_rate    <= RATE_BITS'(8000);
         cfg_ff.frame_limit <= {CAP_BITS{1'b1}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/pfrc_front.sv
// Front end: converts one source frame into destination format and channel layout.
module pfrc_front import pfrc_pkg::*; (
   input  cfg_type                cfg,
   input  logic [SAMPLE_BITS-1:0] first_sample,
   input  logic [SAMPLE_BITS-1:0] second_sample,
   input  logic                   final_frame,
   output entry_type              entry
);

   logic signed [SAMPLE_BITS-1:0] c0, c1;
   logic signed [16:0]            sum, sum_adj, avg, v_first, v_second;

   always_comb begin
      c0       = widen(first_sample, cfg.src_wide);
      c1       = cfg.src_stereo ? widen(second_sample, cfg.src_wide) : c0;
      sum      = 17'(c0) + 17'(c1);
      // halve toward zero: bias negative sums by one before the shift
      sum_adj  = sum + 17'(sum[16]);
      avg      = sum_adj >>> 1;
      v_first  = (cfg.src_stereo && !cfg.dst_stereo) ? avg : 17'(c0);
      v_second = 17'(c1);
      entry.first       = narrow(v_first, cfg.dst_wide);
      entry.second      = cfg.dst_stereo ? narrow(v_second, cfg.dst_wide) : '0;
      entry.final_frame = final_frame;
   end

endmodule

>>> src/pfrc_queue.sv
// Short queue of converted frames between front end and sequencer.
module pfrc_queue import pfrc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  entry_type wr_data,
   output logic      full,
   input  logic      rd_en,
   output entry_type rd_data,
   output logic      rd_valid
);

   entry_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 do_wr, do_rd;

   assign full     = count_ff == (QPTR_BITS + 1)'(QUEUE_DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS + 1)'(do_wr) - (QPTR_BITS + 1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> src/pfrc_back.sv
// Phase-accumulator back end: one result per cycle unless stalled, and the result register.
module pfrc_back import pfrc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  entry_type              head,
   input  logic                   head_valid,
   output logic                   head_pop,
   output logic                   empty,
   input  logic                   pop,
   output logic [SAMPLE_BITS-1:0] rsp_out_first,
   output logic [SAMPLE_BITS-1:0] rsp_out_second,
   output logic                   rsp_is_summary,
   output logic [FW_BITS-1:0]     rsp_frames_written,
   output logic                   rsp_run_end
);

   typedef enum logic [2:0] {
      ST_START   = 3'b001,
      ST_RUN     = 3'b010,
      ST_SUMMARY = 3'b100
   } seq_state_type;

   seq_state_type           state_ff, state_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in, cnt_inc;
   logic signed [PHASE_BITS-1:0] phase_ff, phase_in;
   logic signed [Q_BITS-1:0] q_ff, q_in;
   logic [N_BITS-1:0]       n_ff, n_in;
   logic                    entered_ff, entered_in;
   logic [SAMPLE_BITS-1:0]  held_a_ff, held_a_in, held_b_ff, held_b_in;

   logic                    out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0]  out_first_ff, out_first_in, out_second_ff, out_second_in;
   logic                    out_summary_ff, out_summary_in, out_end_ff, out_end_in;
   logic [FW_BITS-1:0]      out_frames_ff, out_frames_in;

   logic signed [Q_BITS-1:0] sr, dr, q_cur, q_sr, q_2sr, q_end, q_diff;
   logic [N_BITS-1:0]       n_cur;
   logic                    first, in_loop, full_cur, full_next, entered_cur;
   logic                    emit, more, finish, need_slot, slot_free, fire, summary_now;
   logic [SAMPLE_BITS-1:0]  held_a_cur, held_b_cur;

   function automatic logic in_window(input logic signed [Q_BITS-1:0] q,
                                      input logic signed [Q_BITS-1:0] d);
      return (q >= 0) && (q < d);
   endfunction

   always_comb begin
      sr      = $signed(Q_BITS'(clamp_rate(cfg.src_rate)));
      dr      = $signed(Q_BITS'(clamp_rate(cfg.dst_rate)));
      first   = state_ff == ST_START;
      in_loop = state_ff != ST_SUMMARY;
      cnt_inc = count_ff + COUNT_BITS'(1);
      full_cur  = (CMP_BITS'(count_ff) >= CMP_BITS'(cfg.frame_limit)) ||
                  (count_ff == {COUNT_BITS{1'b1}});
      full_next = (CMP_BITS'(cnt_inc) >= CMP_BITS'(cfg.frame_limit)) ||
                  (cnt_inc == {COUNT_BITS{1'b1}});
      q_cur       = first ? Q_BITS'(phase_ff) : q_ff;
      n_cur       = first ? '0 : n_ff;
      entered_cur = first ? !full_cur : entered_ff;
      // latch the current frame when it is the nearest-earlier source for the pending slot
      if (first && !full_cur && in_window(q_cur, dr)) begin
         held_a_cur = head.first;
         held_b_cur = head.second;
      end else begin
         held_a_cur = held_a_ff;
         held_b_cur = held_b_ff;
      end
      q_sr  = q_cur + sr;
      q_2sr = q_sr + sr;
      emit  = in_loop && !full_cur && (n_cur < N_BITS'(MAX_RATIO)) && (q_sr <= dr);
      more  = !full_next && ((n_cur + N_BITS'(1)) < N_BITS'(MAX_RATIO)) && (q_2sr <= dr);
      finish      = in_loop && !(emit && more);
      summary_now = (state_ff == ST_SUMMARY) || (finish && !emit && head.final_frame);
      need_slot   = emit || summary_now;
      slot_free   = !out_valid_ff || pop;
      fire        = head_valid && (!need_slot || slot_free);
      head_pop    = fire && (summary_now || (finish && !head.final_frame));
      q_end  = emit ? q_sr : q_cur;
      q_diff = q_end - dr;
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_START, ST_RUN: begin
            if (fire) begin
               if (!finish) begin
                  state_in = ST_RUN;
               end else if (emit && head.final_frame) begin
                  state_in = ST_SUMMARY;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_SUMMARY: begin
            if (fire) begin
               state_in = ST_START;
            end
         end
         default: state_in = ST_START;
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      phase_in   = phase_ff;
      q_in       = q_ff;
      n_in       = n_ff;
      entered_in = entered_ff;
      held_a_in  = held_a_ff;
      held_b_in  = held_b_ff;
      if (fire && in_loop) begin
         entered_in = entered_cur;
         held_a_in  = held_a_cur;
         held_b_in  = held_b_cur;
         if (emit) begin
            count_in = cnt_inc;
            q_in     = q_sr;
            n_in     = n_cur + N_BITS'(1);
            if (in_window(q_sr, dr)) begin
               held_a_in = head.first;
               held_b_in = head.second;
            end
         end
         if (finish && entered_cur) begin
            if (q_diff > Q_PHASE_MAX) begin
               phase_in = Q_PHASE_MAX[PHASE_BITS-1:0];
            end else if (q_diff < Q_PHASE_MIN) begin
               phase_in = Q_PHASE_MIN[PHASE_BITS-1:0];
            end else begin
               phase_in = q_diff[PHASE_BITS-1:0];
            end
         end
      end
      // buffer closes: drop the pending frame and start over
      if (fire && summary_now) begin
         count_in  = '0;
         phase_in  = '0;
         held_a_in = '0;
         held_b_in = '0;
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff && !pop;
      out_first_in   = out_first_ff;
      out_second_in  = out_second_ff;
      out_summary_in = out_summary_ff;
      out_frames_in  = out_frames_ff;
      out_end_in     = out_end_ff;
      if (fire && need_slot) begin
         out_valid_in = 1'b1;
         if (emit) begin
            out_first_in   = held_a_cur;
            out_second_in  = held_b_cur;
            out_summary_in = 1'b0;
            out_frames_in  = frames_of(cnt_inc);
            out_end_in     = !more && !head.final_frame;
         end else begin
            out_first_in   = '0;
            out_second_in  = '0;
            out_summary_in = 1'b1;
            out_frames_in  = frames_of(count_ff);
            out_end_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_START;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         phase_ff     <= '0;
         held_a_ff    <= '0;
         held_b_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         held_a_ff    <= held_a_in;
         held_b_ff    <= held_b_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff           <= q_in;
      n_ff           <= n_in;
      entered_ff     <= entered_in;
      out_first_ff   <= out_first_in;
      out_second_ff  <= out_second_in;
      out_summary_ff <= out_summary_in;
      out_frames_ff  <= out_frames_in;
      out_end_ff     <= out_end_in;
   end

   assign empty              = !out_valid_ff;
   assign rsp_out_first      = out_first_ff;
   assign rsp_out_second     = out_second_ff;
   assign rsp_is_summary     = out_summary_ff;
   assign rsp_frames_written = out_frames_ff;
   assign rsp_run_end        = out_end_ff;

endmodule

>>> src/pcm_format_rate_converter.sv
// Top level of the PCM format and rate converter.
//
// Nearest-earlier PCM resampler with sample format and channel conversion. Each source
// frame pushed in is converted at once (8-bit offset or 16-bit signed, mono or stereo,
// stereo to mono by averaging toward zero, saturated to the destination format) and
// written into a four-entry frame queue. A sequencer behind the queue runs the phase
// accumulator and, while the result register is not held, emits one beat per cycle into
// it: destination frames whose nearest-earlier source frame this is, then a summary beat
// with the frame count after a frame marked final. A source frame yields at most 12 data
// beats, the rest carried to the next frame. The summary beat of a final frame follows
// its data beats as a step of its own, or is issued with the frame if it yields none.
// Downsampling runs at one frame per cycle while the result register is not held;
// upsampling runs at the result rate. The result register holds a beat until pop, and
// the frame queue keeps accepting frames meanwhile until its four entries are taken.
// With the queue and the result register free, the first beat of an accepted frame is
// registered in the frame queue and then in the result register before it shows on the
// result ports. Configuration registers sit at byte addresses 4*i (src_wide, src_stereo,
// dst_wide, dst_stereo, src_rate, dst_rate, frame_limit); write them only while no frame
// is in flight. Rates are clamped to 4000..48000 Hz.
module pcm_format_rate_converter import pfrc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // source frames
   input  logic                     push,
   output logic                     full,
   input  logic [SAMPLE_BITS-1:0]   req_first_sample,
   input  logic [SAMPLE_BITS-1:0]   req_second_sample,
   input  logic                     req_final_frame,
   // destination frames and summaries
   output logic                     empty,
   input  logic                     pop,
   output logic [SAMPLE_BITS-1:0]   rsp_out_first,
   output logic [SAMPLE_BITS-1:0]   rsp_out_second,
   output logic                     rsp_is_summary,
   output logic [FW_BITS-1:0]       rsp_frames_written,
   output logic                     rsp_run_end,
   // configuration
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type   cfg;
   entry_type front_entry, head;
   logic      head_valid, head_pop;

   // register file; writes land at the access phase
   pfrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // format and channel conversion ahead of the queue
   pfrc_front u_front (
      .cfg           (cfg),
      .first_sample  (req_first_sample),
      .second_sample (req_second_sample),
      .final_frame   (req_final_frame),
      .entry         (front_entry)
   );

   // hold converted frames while the sequencer works off earlier ones
   pfrc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (push),
      .wr_data  (front_entry),
      .full     (full),
      .rd_en    (head_pop),
      .rd_data  (head),
      .rd_valid (head_valid)
   );

   // phase accumulator, emission sequencing and the result register
   pfrc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .head               (head),
      .head_valid         (head_valid),
      .head_pop           (head_pop),
      .empty              (empty),
      .pop                (pop),
      .rsp_out_first      (rsp_out_first),
      .rsp_out_second     (rsp_out_second),
      .rsp_is_summary     (rsp_is_summary),
      .rsp_frames_written (rsp_frames_written),
      .rsp_run_end        (rsp_run_end)
   );

endmodule

>>> src/pfrc_checker.sv
// Port-level checks on the result channel of the converter, with the bind that attaches them.
module pfrc_checker import pfrc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   empty,
   input logic                   pop,
   input logic [SAMPLE_BITS-1:0] rsp_out_first,
   input logic [SAMPLE_BITS-1:0] rsp_out_second,
   input logic                   rsp_is_summary,
   input logic [FW_BITS-1:0]     rsp_frames_written,
   input logic                   rsp_run_end
);

   // a waiting beat stays valid, with its frame count and summary flag, until it is taken
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_frames_written) && $stable(rsp_is_summary)))
      else $error("result beat changed while stalled");

   // a summary closes the run of its frame
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_is_summary) |-> rsp_run_end)
      else $error("summary beat without run end");

   // a summary carries no samples
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_is_summary) |-> (rsp_out_first == '0 && rsp_out_second == '0))
      else $error("summary beat with sample data");

   // a data beat counts itself
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_is_summary) |-> (rsp_frames_written != '0))
      else $error("data beat with zero frame count");

endmodule

bind pcm_format_rate_converter pfrc_checker u_pfrc_checker (.*);
